>>> src/lapedge_pkg.sv
// Types, register codes and per-channel arithmetic for the Laplacian edge filter.
// Used by lapedge_cell and laplacian_edge_3x3_rgb; depends on nothing.
package lapedge_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [9:0]  WIDTH_RESET  = 10'd512;
  localparam logic [11:0] HEIGHT_RESET = 12'd288;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // top, middle and bottom sample of one window column
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } colsum_t;

  function automatic colsum_t col_sum(input column_t c);
    colsum_t s;
    s.r = 10'(c.top.r) + 10'(c.mid.r) + 10'(c.bot.r);
    s.g = 10'(c.top.g) + 10'(c.mid.g) + 10'(c.bot.g);
    s.b = 10'(c.top.b) + 10'(c.mid.b) + 10'(c.bot.b);
    return s;
  endfunction

  // 8*centre - neighbours == 9*centre - sum of all nine, clamped to 0..255
  function automatic logic [7:0] lap_chan(input logic [7:0] centre, input logic [9:0] sa,
                                          input logic [9:0] sb, input logic [9:0] sc);
    logic [11:0] nine;
    logic [11:0] total;
    logic [11:0] diff;
    logic [7:0]  res;
    nine  = {1'b0, centre, 3'b000} + 12'(centre);
    total = 12'(sa) + 12'(sb) + 12'(sc);
    diff  = nine - total;
    if (nine < total) begin
      res = 8'd0;
    end else if (diff > 12'd255) begin
      res = 8'd255;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

endpackage

>>> src/laplacian_edge_3x3_rgb.sv
// 3x3 Laplacian edge filter on an RGB raster stream; top level.
// Depends on lapedge_pkg, lapedge_ram and lapedge_cell.
//
// Takes one pixel per clock in raster order, unless the output stalls, and gives
// one result per interior pixel, at most one per clock: each channel is 8*centre
// minus its eight neighbours, clamped to 0..255. The pixel at column x, row y
// (both >= 2) yields the result for column x-1, row y-1; frame_last marks the last
// result of a frame; frames follow back to back. An item passes the input register
// and line-store read (one read and one write port, both lines kept in one word of
// a MAX_LINE-deep RAM), then the column cells and Laplacian into the output
// register. The user must write width and height only while idle; the block does
// not enforce it. Width is saturated to 3..MAX_LINE, height raised to >= 3.
module laplacian_edge_3x3_rgb #(
  parameter int MAX_LINE = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lapedge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lapedge_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          red_in,
  input  logic [7:0]                          green_in,
  input  logic [7:0]                          blue_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          red_edge,
  output logic [7:0]                          green_edge,
  output logic [7:0]                          blue_edge,
  output logic                                frame_last
);

  localparam int CW = $clog2(MAX_LINE);
  localparam logic [12:0] MAX_W = 13'(MAX_LINE);

  logic [9:0]  image_width;
  logic [11:0] image_height;
  logic [CW-1:0] column_count;
  logic [11:0]   row_count;

  logic                 s1_valid;
  lapedge_pkg::pixel_t  s1_pix;
  logic [CW-1:0]        s1_idx;
  logic                 s1_emit;
  logic                 s1_last;

  logic in_fire;
  logic s1_fire;
  logic [12:0] w_raw;
  logic [12:0] w_eff;
  logic [11:0] h_eff;
  logic [12:0] x_inc;
  logic [12:0] y_inc;
  logic line_end;
  logic frame_end;
  logic emit;

  lapedge_pkg::pixel_t  pix;
  logic [47:0]          rd_word;
  lapedge_pkg::column_t cur_col;
  lapedge_pkg::colsum_t cur_sum;
  lapedge_pkg::column_t col0;
  lapedge_pkg::column_t col1;
  lapedge_pkg::colsum_t sum0;
  lapedge_pkg::colsum_t sum1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lapedge_pkg::WIDTH_RESET;
      image_height <= lapedge_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lapedge_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[9:0];
        lapedge_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1 moves whenever the output register is free or being emptied
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    w_raw = 13'(image_width);
    if (w_raw < 13'd3) begin
      w_eff = 13'd3;
    end else if (w_raw > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = w_raw;
    end
    h_eff     = (image_height < 12'd3) ? 12'd3 : image_height;
    x_inc     = 13'(column_count) + 13'd1;
    y_inc     = 13'(row_count) + 13'd1;
    line_end  = x_inc >= w_eff;
    frame_end = line_end && (y_inc >= 13'(h_eff));
    emit      = (13'(column_count) >= 13'd2) && (row_count >= 12'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (line_end) begin
        column_count <= '0;
        row_count    <= frame_end ? 12'd0 : y_inc[11:0];
      end else begin
        column_count <= x_inc[CW-1:0];
      end
    end
  end

  assign pix = '{r: red_in, g: green_in, b: blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_fire) begin
      s1_pix  <= pix;
      s1_idx  <= column_count;
      s1_emit <= emit;
      s1_last <= frame_end;
    end
  end

  // word: older line in the upper half, newer line in the lower half
  lapedge_ram #(
    .WIDTH(48),
    .DEPTH(MAX_LINE)
  ) u_lines (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_idx),
    .wdata({rd_word[23:0], s1_pix}),
    .re   (in_fire),
    .raddr(column_count),
    .rdata(rd_word)
  );

  assign cur_col.top = rd_word[47:24];
  assign cur_col.mid = rd_word[23:0];
  assign cur_col.bot = s1_pix;
  assign cur_sum     = lapedge_pkg::col_sum(cur_col);

  lapedge_cell u_cell0 (
    .clk    (clk),
    .en     (s1_fire),
    .col_in (cur_col),
    .col_out(col0),
    .sum_out(sum0)
  );

  lapedge_cell u_cell1 (
    .clk    (clk),
    .en     (s1_fire),
    .col_in (col0),
    .col_out(col1),
    .sum_out(sum1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (s1_fire && s1_emit) || (out_valid && !out_ready);
    end
    if (s1_fire && s1_emit) begin
      red_edge   <= lapedge_pkg::lap_chan(col0.mid.r, cur_sum.r, sum0.r, sum1.r);
      green_edge <= lapedge_pkg::lap_chan(col0.mid.g, cur_sum.g, sum0.g, sum1.g);
      blue_edge  <= lapedge_pkg::lap_chan(col0.mid.b, cur_sum.b, sum0.b, sum1.b);
      frame_last <= s1_last;
    end
  end

endmodule

>>> src/lapedge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lapedge_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lapedge_cell.sv
// One window column cell: holds a column of three pixels and its per-channel sum,
// hands the column on to the next cell. Depends on lapedge_pkg.
module lapedge_cell (
  input  logic                 clk,
  input  logic                 en,
  input  lapedge_pkg::column_t col_in,
  output lapedge_pkg::column_t col_out,
  output lapedge_pkg::colsum_t sum_out
);

  always_ff @(posedge clk) begin
    if (en) begin
      col_out <= col_in;
      sum_out <= lapedge_pkg::col_sum(col_in);
    end
  end

endmodule
